@@ src/bmc_pkg.sv @@
// Shared types and constants for the bus mouse controller.
`timescale 1ns / 1ps

package bmc_pkg;

  // Width of the saturating motion accumulators
  localparam int ACCUM_BITS = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_VARIANT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEWER   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IRQ     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_THREE   = 2'd3;

  // Register offsets
  localparam logic [1:0] PORT_0 = 2'd0;
  localparam logic [1:0] PORT_1 = 2'd1;
  localparam logic [1:0] PORT_2 = 2'd2;
  localparam logic [1:0] PORT_3 = 2'd3;

  // Data port command indexes (alternative map)
  localparam logic [2:0] CMD_STATUS = 3'd0;
  localparam logic [2:0] CMD_X      = 3'd1;
  localparam logic [2:0] CMD_Y      = 3'd2;
  localparam logic [2:0] CMD_MODE   = 3'd7;

  // Report period codes (alternative map)
  localparam logic [2:0] PERIOD_OFF    = 3'd0;
  localparam logic [2:0] PERIOD_MAXRUN = 3'd4;
  localparam logic [2:0] PERIOD_HOLD   = 3'd6;

  // Fixed report rate of the standard map
  localparam logic [2:0] RATE_45HZ = 3'd5;

  localparam logic [7:0] SIG_A      = 8'h12;
  localparam logic [7:0] SIG_B      = 8'hDE;
  localparam logic [7:0] CTRL_LOW   = 8'h0F;
  localparam logic [7:0] CONFIG_RST = 8'h0E;
  localparam logic [2:0] IRQ_RST    = 3'd5;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_MOVE  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    IRQ_NONE     = 2'd0,
    IRQ_DEASSERT = 2'd1,
    IRQ_PULSE    = 2'd2
  } irq_act_t;

  typedef struct packed {
    op_t                op;
    logic [1:0]         port;
    logic [7:0]         write_data;
    logic signed [15:0] move_dx;
    logic signed [15:0] move_dy;
    logic [4:0]         host_buttons;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    irq_act_t   irq_action;
    logic       move_ignored;
    logic [2:0] report_rate;
  } out_word_t;

  // Accumulator controls
  typedef struct packed {
    logic clear;
    logic add;
    logic drain;
  } accum_ctl_t;

endpackage

@@ src/bus_mouse_controller_top.sv @@
// Top level of the four-register PC bus mouse adapter.
`timescale 1ns / 1ps

// Bus mouse adapter with a standard and an alternative register map. Each
// input word is a bus read, a bus write, a host movement or a report tick,
// and gives exactly one result word. Throughput is one word per clock while
// the result side does not stall; a word passes the input register, then the
// result register, and the input register doubles as the skid stage while
// the result side stalls. All register-map work for a word is combinational
// between the two registers. Writing the variant register resets all adapter
// state to the chosen map's defaults; the user writes configuration only while
// the block is idle (the block does not enforce this). cfg_ready is always high.
module bus_mouse_controller_top
  import bmc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_word_t               in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_word_t              out_word,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic       variant_r, newer_r, three_r;
  logic [2:0] irq_line_r;

  // Adapter state
  logic [7:0]  control_r, control_nxt;
  logic [7:0]  config_r, config_nxt;
  logic [7:0]  signature_r, signature_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [10:0] toggle_r, toggle_nxt;
  logic        hold_r, hold_nxt;
  logic        tirq_r, tirq_nxt;
  logic        dirq_r, dirq_nxt;
  logic        tmode_r, tmode_nxt;
  logic [2:0]  rate_r, rate_nxt;
  logic [7:0]  lx_r, lx_nxt;
  logic [7:0]  ly_r, ly_nxt;
  logic [7:0]  lbtn_r, lbtn_nxt;
  logic [7:0]  bstat_r, bstat_nxt;
  logic [4:0]  prev_r, prev_nxt;

  // Pipeline registers
  logic      in_valid_r, out_valid_r;
  in_word_t  in_word_r;
  out_word_t out_word_r, res;

  logic       accept, advance, cfg_we, init_wr, init_variant;
  accum_ctl_t acc_ctl;
  logic signed [7:0] cdx, cdy, chunk_x, chunk_y;
  logic [4:0] chg;
  logic [7:0] btn, nib, clr_bit;
  logic [2:0] wr_low;

  assign cfg_ready    = 1'b1;
  assign cfg_we       = cfg_valid && cfg_ready;
  assign init_wr      = cfg_we && (cfg_index == CFG_VARIANT);
  assign init_variant = rst_n ? cfg_data[0] : 1'b0;

  // Handshake: input register acts as skid stage
  assign advance   = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = in_valid_r && out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Clamp host deltas to signed bytes
  always_comb begin
    if (in_word_r.move_dx > 16'sd127) begin
      cdx = 8'sd127;
    end else if (in_word_r.move_dx < -16'sd128) begin
      cdx = -8'sd128;
    end else begin
      cdx = in_word_r.move_dx[7:0];
    end
    if (in_word_r.move_dy > 16'sd127) begin
      cdy = 8'sd127;
    end else if (in_word_r.move_dy < -16'sd128) begin
      cdy = -8'sd128;
    end else begin
      cdy = in_word_r.move_dy[7:0];
    end
  end

  bmc_accum u_acc_x (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .delta (cdx),
    .chunk (chunk_x)
  );

  bmc_accum u_acc_y (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .delta (cdy),
    .chunk (chunk_y)
  );

  // Helper terms for the register map
  always_comb begin
    chg      = in_word_r.host_buttons ^ prev_r;
    clr_bit  = 8'(8'h20 >> irq_line_r);
    wr_low   = in_word_r.write_data[2:0];
    unique case (control_r[6:5])
      2'd0:    nib = {4'h0, lx_r[3:0]};
      2'd1:    nib = {4'h0, lx_r[7:4]};
      2'd2:    nib = {4'h0, ly_r[3:0]};
      default: nib = {4'h0, ly_r[7:4]};
    endcase
    btn = {5'b0, in_word_r.host_buttons[0], 1'b0, in_word_r.host_buttons[1]};
    if (three_r) btn[1] = in_word_r.host_buttons[2];
    if (variant_r) begin
      btn[6] = (in_word_r.move_dx != '0) || (in_word_r.move_dy != '0);
      btn[5] = chg[0];
      btn[4] = chg[4] && three_r;
      btn[3] = chg[2];
    end
  end

  // Per-word register map logic
  always_comb begin
    control_nxt   = control_r;
    config_nxt    = config_r;
    signature_nxt = signature_r;
    cmd_nxt       = cmd_r;
    toggle_nxt    = toggle_r;
    hold_nxt      = hold_r;
    tirq_nxt      = tirq_r;
    dirq_nxt      = dirq_r;
    tmode_nxt     = tmode_r;
    rate_nxt      = rate_r;
    lx_nxt        = lx_r;
    ly_nxt        = ly_r;
    lbtn_nxt      = lbtn_r;
    bstat_nxt     = bstat_r;
    prev_nxt      = prev_r;
    acc_ctl       = '0;
    acc_ctl.clear = init_wr;
    res           = '0;
    res.irq_action = IRQ_NONE;

    if (advance) begin
      unique case (in_word_r.op)
        OP_READ: begin
          if (variant_r) begin
            unique case (in_word_r.port)
              PORT_0: res.read_data = control_r;
              PORT_1: begin
                priority if (cmd_r == CMD_STATUS) begin
                  res.read_data = lbtn_r | 8'h80 | (newer_r ? 8'h40 : 8'h00);
                end else if (cmd_r == CMD_X) begin
                  res.read_data = lx_r;
                end else if (cmd_r == CMD_Y) begin
                  res.read_data = ly_r;
                end else if (cmd_r == CMD_MODE) begin
                  res.read_data = control_r;
                end else begin
                  res.read_data = '0;
                end
              end
              PORT_2: begin
                res.read_data = (toggle_r != '0) ? SIG_A : SIG_B;
                toggle_nxt    = toggle_r ^ 11'd1;
              end
              default: res.read_data = '0;
            endcase
          end else begin
            unique case (in_word_r.port)
              PORT_0: res.read_data = nib | {lbtn_r[2:0] ^ 3'b111, 5'b0};
              PORT_1: res.read_data = signature_r;
              PORT_2: begin
                res.read_data = control_r;
                control_nxt   = control_r | CTRL_LOW;
                // interrupt bit drops while read count bit 10 is set (after 1024 reads), unless newer_r && !tirq_r
                if (toggle_r[10] && (!newer_r || tirq_r)) begin
                  control_nxt = control_nxt & ~clr_bit;
                end
                toggle_nxt = toggle_r + 11'd1;
              end
              default: res.read_data = config_r;
            endcase
          end
        end

        OP_WRITE: begin
          if (variant_r) begin
            if (in_word_r.port == PORT_0) begin
              if (in_word_r.write_data[7]) control_nxt = '0;
              if (wr_low <= CMD_Y || wr_low == CMD_MODE) cmd_nxt = wr_low;
            end else if (in_word_r.port == PORT_1) begin
              res.irq_action = IRQ_DEASSERT;
              if (cmd_r == CMD_MODE) begin
                hold_nxt = in_word_r.write_data[5];
                tirq_nxt = in_word_r.write_data[4];
                dirq_nxt = in_word_r.write_data[3];
                if (wr_low == PERIOD_HOLD) begin
                  if (in_word_r.write_data[4]) res.irq_action = IRQ_PULSE;
                  control_nxt = {in_word_r.write_data[7:3], control_r[2:0]};
                end else begin
                  if (wr_low == PERIOD_OFF) begin
                    rate_nxt  = PERIOD_OFF;
                    tmode_nxt = 1'b0;
                  end else if (wr_low <= PERIOD_MAXRUN) begin
                    rate_nxt  = wr_low;
                    tmode_nxt = in_word_r.write_data[4];
                  end
                  control_nxt = in_word_r.write_data;
                end
              end
            end
          end else begin
            unique case (in_word_r.port)
              PORT_2: begin
                control_nxt    = in_word_r.write_data | CTRL_LOW;
                tirq_nxt       = !in_word_r.write_data[4];
                hold_nxt       = in_word_r.write_data[7];
                res.irq_action = IRQ_DEASSERT;
              end
              PORT_3:  config_nxt    = in_word_r.write_data;
              PORT_1:  signature_nxt = in_word_r.write_data;
              default: ;
            endcase
          end
        end

        OP_MOVE: begin
          if (in_word_r.move_dx == '0 && in_word_r.move_dy == '0 &&
              (variant_r ? (chg[2:0] == '0) : (chg == '0))) begin
            res.move_ignored = 1'b1;
          end else begin
            bstat_nxt = btn;
            prev_nxt  = in_word_r.host_buttons;
            if (tmode_r) begin
              acc_ctl.add = 1'b1;
            end else begin
              if (!hold_r) begin
                lx_nxt   = cdx;
                ly_nxt   = cdy;
                lbtn_nxt = btn;
              end
              if (dirq_r) res.irq_action = IRQ_PULSE;
            end
          end
        end

        default: begin
          // report tick
          if (tmode_r) begin
            if (tirq_r) res.irq_action = IRQ_PULSE;
            acc_ctl.drain = 1'b1;
            if (!hold_r) begin
              lx_nxt   = chunk_x;
              ly_nxt   = chunk_y;
              lbtn_nxt = bstat_r;
            end
          end
        end
      endcase
    end

    res.report_rate = !tmode_nxt ? 3'd0 : (variant_r ? rate_nxt : RATE_45HZ);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r  <= 1'b0;
      newer_r    <= 1'b0;
      irq_line_r <= IRQ_RST;
      three_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VARIANT: variant_r  <= cfg_data[0];
        CFG_NEWER:   newer_r    <= cfg_data[0];
        CFG_IRQ:     irq_line_r <= cfg_data;
        default:     three_r    <= cfg_data[0];
      endcase
    end
  end

  // Adapter state, reset by rst_n or a variant write
  always_ff @(posedge clk) begin
    if (!rst_n || init_wr) begin
      control_r   <= init_variant ? 8'h00 : CTRL_LOW;
      tmode_r     <= !init_variant;
      config_r    <= CONFIG_RST;
      signature_r <= '0;
      cmd_r       <= '0;
      toggle_r    <= '0;
      hold_r      <= 1'b0;
      tirq_r      <= 1'b0;
      dirq_r      <= 1'b0;
      rate_r      <= '0;
      lx_r        <= '0;
      ly_r        <= '0;
      lbtn_r      <= '0;
      bstat_r     <= '0;
      prev_r      <= '0;
    end else begin
      control_r   <= control_nxt;
      tmode_r     <= tmode_nxt;
      config_r    <= config_nxt;
      signature_r <= signature_nxt;
      cmd_r       <= cmd_nxt;
      toggle_r    <= toggle_nxt;
      hold_r      <= hold_nxt;
      tirq_r      <= tirq_nxt;
      dirq_r      <= dirq_nxt;
      rate_r      <= rate_nxt;
      lx_r        <= lx_nxt;
      ly_r        <= ly_nxt;
      lbtn_r      <= lbtn_nxt;
      bstat_r     <= bstat_nxt;
      prev_r      <= prev_nxt;
    end
  end

  // Input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_word_r <= in_word;
    if (advance) out_word_r <= res;
  end

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed word lost before result register");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && !advance)
    else $error("input stalled with nothing held");

  a_std_timer: assert property (@(posedge clk) disable iff (!rst_n)
    !variant_r |-> tmode_r)
    else $error("standard map left timer mode");

  a_ignored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.move_ignored |->
      out_word_r.irq_action == IRQ_NONE && out_word_r.read_data == '0)
    else $error("ignored movement produced side results");

endmodule

@@ src/bmc_accum.sv @@
// One axis of saturating motion accumulation with byte-sized draining.
`timescale 1ns / 1ps

module bmc_accum
  import bmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  accum_ctl_t        ctl,
  input  logic signed [7:0] delta,
  output logic signed [7:0] chunk
);

  localparam logic signed [ACCUM_BITS-1:0] CHUNK_HI = ACCUM_BITS'(127);
  localparam logic signed [ACCUM_BITS-1:0] CHUNK_LO = -CHUNK_HI - ACCUM_BITS'(1);
  localparam logic signed [ACCUM_BITS-1:0] SAT_HI   = {1'b0, {(ACCUM_BITS-1){1'b1}}};
  localparam logic signed [ACCUM_BITS-1:0] SAT_LO   = {1'b1, {(ACCUM_BITS-1){1'b0}}};

  logic signed [ACCUM_BITS-1:0] acc_r, acc_nxt;
  logic signed [ACCUM_BITS:0]   sum;
  logic signed [ACCUM_BITS-1:0] sat_sum;
  logic signed [ACCUM_BITS-1:0] drained;

  // Saturating add of one clamped delta
  always_comb begin
    sum = {acc_r[ACCUM_BITS-1], acc_r} + (ACCUM_BITS+1)'(delta);
    if (sum[ACCUM_BITS] != sum[ACCUM_BITS-1]) begin
      sat_sum = sum[ACCUM_BITS] ? SAT_LO : SAT_HI;
    end else begin
      sat_sum = sum[ACCUM_BITS-1:0];
    end
  end

  // Take at most one signed byte out
  always_comb begin
    if (acc_r > CHUNK_HI) begin
      chunk   = 8'sd127;
      drained = acc_r - CHUNK_HI;
    end else if (acc_r < CHUNK_LO) begin
      chunk   = -8'sd128;
      drained = acc_r - CHUNK_LO;
    end else begin
      chunk   = acc_r[7:0];
      drained = '0;
    end
  end

  always_comb begin
    priority if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.add) begin
      acc_nxt = sat_sum;
    end else if (ctl.drain) begin
      acc_nxt = drained;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  a_add_drain_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.add && ctl.drain))
    else $error("accumulator add and drain in the same cycle");

  a_sat_stays: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.add && !ctl.clear && acc_r == SAT_HI && !delta[7] |=> acc_r == SAT_HI)
    else $error("accumulator wrapped past positive limit");

  a_drain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.drain && !ctl.clear && !ctl.add && acc_r <= CHUNK_HI && acc_r >= CHUNK_LO
    |=> acc_r == '0)
    else $error("small accumulator not emptied by drain");

endmodule
